// ===== src/stbs_pkg.sv =====
package stbs_pkg;

   localparam int DEPTH_DEFAULT = 1024;
   localparam int KEY_BITS_DEFAULT = 64;

   localparam int INDEX_WIDTH = 10;
   localparam int POSITION_WIDTH = 10;
   localparam int SIZE_WIDTH = 11;
   localparam int KEY_PORT_WIDTH = 64;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   typedef struct packed {
      logic load;
      logic start;
      logic probe;
      logic check;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic range_empty;
      logic key_hit;
   } status_type;

endpackage

// ===== src/stbs_ctrl.sv =====
module stbs_ctrl
   import stbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_type,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PROBE = 2'd1;
   localparam logic [1:0] S_CHECK = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.load = accept && (req_type == REQ_LOAD);
      cmd.start = accept && (req_type == REQ_LOOKUP);
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (status.range_empty) begin
               state_in = S_DONE;
            end else begin
               cmd.probe = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (status.key_hit) begin
               state_in = S_DONE;
            end else begin
               state_in = S_PROBE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/stbs_datapath.sv =====
module stbs_datapath
   import stbs_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int KEY_BITS = KEY_BITS_DEFAULT
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [SIZE_WIDTH-1:0]     csr_write_data,
   input  logic [INDEX_WIDTH-1:0]    req_entry_index,
   input  logic [KEY_PORT_WIDTH-1:0] req_key_value,
   input  logic [POSITION_WIDTH-1:0] req_entry_position,
   output logic                      rsp_found,
   output logic [POSITION_WIDTH-1:0] rsp_position,
   input  cmd_type                   cmd,
   output status_type                status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = AW + 1;
   localparam int MW = (CW > SIZE_WIDTH) ? CW : SIZE_WIDTH;
   localparam int IW = (CW > INDEX_WIDTH) ? CW : INDEX_WIDTH;

   logic [KEY_BITS-1:0]       key_mem [DEPTH];
   logic [POSITION_WIDTH-1:0] pos_mem [DEPTH];

   logic [SIZE_WIDTH-1:0]     size_ff;
   logic [KEY_BITS-1:0]       key_ff;
   logic [CW-1:0]             low_ff;
   logic [CW-1:0]             high_ff;
   logic [AW-1:0]             mid_ff;
   logic [KEY_BITS-1:0]       key_rd_ff;
   logic [POSITION_WIDTH-1:0] pos_rd_ff;
   logic                      found_ff;
   logic [POSITION_WIDTH-1:0] pos_ff;
   logic                      rsp_found_ff;
   logic [POSITION_WIDTH-1:0] rsp_position_ff;

   logic [MW-1:0]             size_ext;
   logic [CW-1:0]             size_sat;
   logic [AW+1:0]             mid_sum;
   logic [AW-1:0]             mid;
   logic                      index_ok;
   logic [AW-1:0]             wr_addr;

   // High is kept one past the last live entry, so the range is empty when low reaches it.
   assign size_ext = MW'(size_ff);
   assign size_sat = (size_ext > MW'(DEPTH)) ? CW'(DEPTH) : CW'(size_ext);
   assign mid_sum = (AW+2)'(low_ff) + (AW+2)'(high_ff) - (AW+2)'(1);
   assign mid = mid_sum[AW:1];
   assign index_ok = IW'(req_entry_index) < IW'(DEPTH);
   assign wr_addr = AW'(req_entry_index);

   assign status.range_empty = (low_ff >= high_ff);
   assign status.key_hit = (key_rd_ff == key_ff);

   assign rsp_found = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
      end else if (csr_write_enable) begin
         size_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && index_ok) begin
         key_mem[wr_addr] <= req_key_value[KEY_BITS-1:0];
         pos_mem[wr_addr] <= req_entry_position;
      end
      if (cmd.probe) begin
         key_rd_ff <= key_mem[mid];
         pos_rd_ff <= pos_mem[mid];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff <= req_key_value[KEY_BITS-1:0];
         low_ff <= '0;
         high_ff <= size_sat;
         found_ff <= 1'b0;
         pos_ff <= '0;
      end else if (cmd.check) begin
         if (key_rd_ff == key_ff) begin
            found_ff <= 1'b1;
            pos_ff <= pos_rd_ff;
         end else if (key_rd_ff > key_ff) begin
            high_ff <= CW'(mid_ff);
         end else begin
            low_ff <= CW'(mid_ff) + CW'(1);
         end
      end
      if (cmd.probe) begin
         mid_ff <= mid;
      end
      if (cmd.publish) begin
         rsp_found_ff <= found_ff;
         rsp_position_ff <= pos_ff;
      end
   end

endmodule

// ===== src/sorted_table_binary_search.sv =====
// Sorted-table lookup engine. Load words write one key and its record position into
// the table and complete in the cycle they are accepted, with no response. Lookup
// words run a binary search over the first table_size entries (clamped to DEPTH) and
// return one response word with found and the stored position (zero on a miss).
// Each probe is a registered table read in the probe state followed by the key
// compare in the check state; a lookup that misses ends with a final empty-range
// check. A search makes at most floor(log2(DEPTH)) + 1 probes. The search waits in
// its done state while the response register is full and not being drained. One
// word is processed at a time; a finished response waits in an output register while
// the next word is accepted.
module sorted_table_binary_search
   import stbs_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int KEY_BITS = KEY_BITS_DEFAULT
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [SIZE_WIDTH-1:0]     csr_write_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_type,
   input  logic [INDEX_WIDTH-1:0]    req_entry_index,
   input  logic [KEY_PORT_WIDTH-1:0] req_key_value,
   input  logic [POSITION_WIDTH-1:0] req_entry_position,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_found,
   output logic [POSITION_WIDTH-1:0] rsp_position
);

   cmd_type    cmd;
   status_type status;

   stbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   stbs_datapath #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_entry_index    (req_entry_index),
      .req_key_value      (req_key_value),
      .req_entry_position (req_entry_position),
      .rsp_found          (rsp_found),
      .rsp_position       (rsp_position),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import stbs_pkg::*;

   localparam int RESET_CYCLES = 6;
   localparam int SETTLE_CYCLES = 30;
   localparam int HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int WORDS_PER_PHASE = 190;
   localparam bit [KEY_PORT_WIDTH-1:0] KEY_ALL_ONES = '1;

   typedef struct packed {
      bit                      hit;
      bit [POSITION_WIDTH-1:0] position;
   } lookup_answer_type;

   typedef struct packed {
      bit [SIZE_WIDTH-1:0]     table_size;
      bit                      kind;
      bit [INDEX_WIDTH-1:0]    slot;
      bit [KEY_PORT_WIDTH-1:0] key;
      bit [POSITION_WIDTH-1:0] posn;
      bit                      typed;
      lookup_answer_type       answer;
   } stim_row_type;

   // The last rows leave the table unsorted, so a present key can be missed.
   localparam stim_row_type DIRECTED_WORDS [17] = '{
      '{11'd0, REQ_LOOKUP, 10'd0,    64'd0,        10'd0,    1'b1, '{1'b0, 10'd0}},
      '{11'd0, REQ_LOOKUP, 10'd1023, KEY_ALL_ONES, 10'd1023, 1'b1, '{1'b0, 10'd0}},
      '{11'd0, REQ_LOAD,   10'd0,    64'd0,        10'd0,    1'b0, '{1'b0, 10'd0}},
      '{11'd0, REQ_LOAD,   10'd1,    64'd5,        10'd1023, 1'b0, '{1'b0, 10'd0}},
      '{11'd0, REQ_LOAD,   10'd2,    KEY_ALL_ONES, 10'd512,  1'b0, '{1'b0, 10'd0}},
      '{11'd0, REQ_LOAD,   10'd1023, KEY_ALL_ONES, 10'd1023, 1'b0, '{1'b0, 10'd0}},
      '{11'd1, REQ_LOOKUP, 10'd0,    64'd0,        10'd0,    1'b1, '{1'b1, 10'd0}},
      '{11'd1, REQ_LOOKUP, 10'd0,    64'd5,        10'd0,    1'b1, '{1'b0, 10'd0}},
      '{11'd3, REQ_LOOKUP, 10'd0,    64'd5,        10'd0,    1'b1, '{1'b1, 10'd1023}},
      '{11'd3, REQ_LOOKUP, 10'd0,    KEY_ALL_ONES, 10'd0,    1'b1, '{1'b1, 10'd512}},
      '{11'd3, REQ_LOOKUP, 10'd0,    64'd3,        10'd0,    1'b0, '{1'b0, 10'd0}},
      '{11'd3, REQ_LOOKUP, 10'd0,    64'd0,        10'd0,    1'b1, '{1'b1, 10'd0}},
      '{11'd3, REQ_LOAD,   10'd1,    64'h8000_0000_0000_0000, 10'd7, 1'b0, '{1'b0, 10'd0}},
      '{11'd3, REQ_LOAD,   10'd2,    64'd1,        10'd3,    1'b0, '{1'b0, 10'd0}},
      '{11'd3, REQ_LOOKUP, 10'd0,    64'h8000_0000_0000_0000, 10'd0, 1'b0, '{1'b0, 10'd0}},
      '{11'd3, REQ_LOOKUP, 10'd0,    64'd1,        10'd0,    1'b0, '{1'b0, 10'd0}},
      '{11'd3, REQ_LOOKUP, 10'd0,    64'd0,        10'd0,    1'b0, '{1'b0, 10'd0}}
   };

   localparam int SEND_IDLE_PCT [4] = '{0, 45, 0, 35};
   localparam int RSP_STALL_PCT [4] = '{0, 0, 45, 35};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [SIZE_WIDTH-1:0]     csr_write_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_type = REQ_LOAD;
   logic [INDEX_WIDTH-1:0]    req_entry_index = '0;
   logic [KEY_PORT_WIDTH-1:0] req_key_value = '0;
   logic [POSITION_WIDTH-1:0] req_entry_position = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_found;
   logic [POSITION_WIDTH-1:0] rsp_position;

   bit [KEY_PORT_WIDTH-1:0]   key_table [DEPTH_DEFAULT];
   bit [POSITION_WIDTH-1:0]   pos_table [DEPTH_DEFAULT];
   bit [SIZE_WIDTH-1:0]       table_size_reg = '0;
   lookup_answer_type         pending_answers [$];
   int                        edge_slots [$];

   int  send_idle_pct = 0;
   int  stall_pct = 0;
   bit  long_hold = 1'b0;
   int  hold_count = 0;
   int  idle_cycles = 0;
   int  mismatches = 0;
   int  words_sent = 0;

   sorted_table_binary_search u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_entry_index    (req_entry_index),
      .req_key_value      (req_key_value),
      .req_entry_position (req_entry_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found          (rsp_found),
      .rsp_position       (rsp_position)
   );

   always #5 clock = ~clock;

   function automatic lookup_answer_type search_table(input bit [KEY_PORT_WIDTH-1:0] key);
      int                low;
      int                high;
      int                mid;
      lookup_answer_type answer;
      answer = '0;
      low = 0;
      high = (table_size_reg > DEPTH_DEFAULT ? DEPTH_DEFAULT : int'(table_size_reg)) - 1;
      while (low <= high) begin
         mid = (low + high) / 2;
         if (key_table[mid] == key) begin
            answer.hit = 1'b1;
            answer.position = pos_table[mid];
            return answer;
         end
         if (key_table[mid] > key) begin
            high = mid - 1;
         end else begin
            low = mid + 1;
         end
      end
      return answer;
   endfunction

   task automatic send_word(input bit kind, input bit [INDEX_WIDTH-1:0] slot,
                            input bit [KEY_PORT_WIDTH-1:0] key,
                            input bit [POSITION_WIDTH-1:0] posn,
                            input bit typed = 1'b0,
                            input lookup_answer_type typed_answer = '0);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_entry_index <= slot;
      req_key_value <= key;
      req_entry_position <= posn;
      do @(posedge clock); while (req_ready !== 1'b1);
      words_sent++;
      if (kind == REQ_LOAD) begin
         key_table[slot] = key;
         pos_table[slot] = posn;
      end else if (typed) begin
         pending_answers.push_back(typed_answer);
      end else begin
         pending_answers.push_back(search_table(key));
      end
   endtask

   task automatic wait_for_answers();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_table_size(input bit [SIZE_WIDTH-1:0] value);
      wait_for_answers();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      table_size_reg = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_lookups(input int count, input int entries);
      int                      sent;
      int                      choice;
      bit [KEY_PORT_WIDTH-1:0] probe_key;
      sent = 0;
      while (sent < count) begin
         choice = $urandom_range(99);
         if (choice >= 90) begin
            send_word(REQ_LOAD, 10'($urandom_range(1023)), {$urandom, $urandom},
                      10'($urandom_range(1023)));
         end else begin
            if (choice < 65) begin
               probe_key = key_table[$urandom_range(entries - 1)];
            end else if (choice < 80) begin
               probe_key = key_table[$urandom_range(entries - 1)]
                           + ($urandom_range(1) ? 64'd1 : KEY_ALL_ONES);
            end else begin
               probe_key = {$urandom, $urandom};
            end
            send_word(REQ_LOOKUP, 10'($urandom_range(1023)), probe_key,
                      10'($urandom_range(1023)));
            sent++;
         end
      end
   endtask

   // Loads only the entries on the leftmost and rightmost probe paths of a full-depth
   // search, with keys that rise with the slot number.
   task automatic load_edge_entries();
      int low;
      int high;
      int mid;
      for (int side = 0; side < 2; side++) begin
         low = 0;
         high = DEPTH_DEFAULT - 1;
         while (low <= high) begin
            mid = (low + high) / 2;
            edge_slots.push_back(mid);
            send_word(REQ_LOAD, 10'(mid),
                      64'(mid) * 64'd1000 + 64'($urandom_range(1, 999)),
                      10'($urandom_range(1023)));
            if (side == 0) begin
               high = mid - 1;
            end else begin
               low = mid + 1;
            end
         end
      end
   endtask

   // Every key either matches an entry on the leftmost or rightmost edge path or lies beyond
   // an end of the table, so a search never leaves the loaded entries.
   task automatic edge_lookups(input int count);
      int                      choice;
      bit [KEY_PORT_WIDTH-1:0] probe_key;
      for (int n = 0; n < count; n++) begin
         choice = $urandom_range(9);
         if (choice == 0) begin
            probe_key = '0;
         end else if (choice == 1) begin
            probe_key = KEY_ALL_ONES;
         end else begin
            probe_key = key_table[edge_slots[$urandom_range(edge_slots.size() - 1)]];
         end
         send_word(REQ_LOOKUP, 10'($urandom_range(1023)), probe_key,
                   10'($urandom_range(1023)));
      end
   endtask

   task automatic run_table_set(input int entries, input int size_value, input int lookups);
      bit [KEY_PORT_WIDTH-1:0] next_key;
      bit [KEY_PORT_WIDTH-1:0] span;
      bit                      dense;
      dense = ($urandom_range(2) == 0);
      span = KEY_ALL_ONES / (entries + 1);
      next_key = dense ? 64'($urandom_range(1000)) : 64'd0;
      for (int i = 0; i < entries; i++) begin
         if (dense) begin
            next_key += 64'($urandom_range(1, 3));
         end else begin
            next_key = 64'(i) * span + ({$urandom, $urandom} % span);
         end
         send_word(REQ_LOAD, 10'(i), next_key, 10'($urandom_range(1023)));
      end
      write_table_size(11'(size_value));
      random_lookups(lookups, entries);
   endtask

   always @(posedge clock) begin : response_check
      lookup_answer_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: response word with no lookup pending, found %0b position %0d",
                     $time, rsp_found, rsp_position);
            mismatches++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_found !== want.hit) begin
               $display("%0t: found expected %0b actual %0b", $time, want.hit, rsp_found);
               mismatches++;
            end
            if (rsp_position !== want.position) begin
               $display("%0t: position expected %0d actual %0d",
                        $time, want.position, rsp_position);
               mismatches++;
            end
         end
      end
      if (long_hold && hold_count < HOLD_CYCLES) begin
         rsp_ready <= 1'b0;
         hold_count++;
      end else begin
         if (!long_hold) begin
            hold_count = 0;
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_ready === 1'b1)
          || (rsp_valid === 1'b1 && rsp_ready === 1'b1)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      int phase_start;
      int entries;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_WORDS[i]) begin
         if (DIRECTED_WORDS[i].table_size != table_size_reg) begin
            write_table_size(DIRECTED_WORDS[i].table_size);
         end
         send_word(DIRECTED_WORDS[i].kind, DIRECTED_WORDS[i].slot, DIRECTED_WORDS[i].key,
                   DIRECTED_WORDS[i].posn, DIRECTED_WORDS[i].typed, DIRECTED_WORDS[i].answer);
      end

      for (int phase = 0; phase < 4; phase++) begin
         wait_for_answers();
         send_idle_pct = SEND_IDLE_PCT[phase];
         stall_pct <= RSP_STALL_PCT[phase];
         phase_start = words_sent;
         while (words_sent - phase_start < WORDS_PER_PHASE) begin
            entries = ($urandom_range(9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
            run_table_set(entries, entries, $urandom_range(10, 30));
         end
         if (phase == 0) begin
            // Full depth, then an oversized size that must behave as the full depth.
            load_edge_entries();
            write_table_size(11'(DEPTH_DEFAULT));
            edge_lookups(20);
            write_table_size(KEY_ALL_ONES[SIZE_WIDTH-1:0]);
            long_hold <= 1'b1;
            edge_lookups(12);
            long_hold <= 1'b0;
            edge_lookups(10);
         end
      end

      wait_for_answers();
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== sorted_table_binary_search.f =====
src/stbs_pkg.sv
src/stbs_ctrl.sv
src/stbs_datapath.sv
src/sorted_table_binary_search.sv
test/tb.sv
